// ===== sv/wgas_pkg.sv =====
// Shared types and constants for the wrap-guarded azimuth smoother.
package wgas_pkg;

	// Default angle resolution: a full turn is 2**ANGLE_BITS_DEF.
	localparam int ANGLE_BITS_DEF = 16;

	// Width of the external heading field.
	localparam int AZ_W = 16;

	// Result queue depth; must be a power of two and at least four.
	localparam int QUEUE_DEPTH = 8;

	// Most results a single input word can cause.
	localparam int MAX_RESULTS = 3;

	// Configuration port: byte address width and register index codes.
	localparam int PADDR_W = 3;
	localparam logic REG_IDX_JUMP_THR = 1'b0;

	// Reset value of the jump threshold: half a turn.
	localparam logic [15:0] JUMP_THR_RESET = 16'h8000;

	// One result word as it waits in the output queue.
	typedef struct packed {
		logic [AZ_W-1:0] az;
		logic            avg;
		logic            run_end;
	} res_t;

endpackage

// ===== sv/wrap_guarded_azimuth_smoother.sv =====
// Top level of the wrap-guarded five-point azimuth smoother.
//
// Heading samples arrive as unsigned binary angles on the slave stream (s_*), one word per
// sample, with s_tlast marking the final sample of a run. Each sample leaves on the master
// stream (m_*) two samples later: interior samples become the truncated mean of their
// centered five-sample window, unless a neighbor difference in that window exceeds the
// jump threshold, in which case the sample passes through. m_tuser flags an averaged word
// and m_tlast marks the last result caused by one input word.
// The jump threshold is written over the APB port at byte address 0.
// A result becomes visible on m_tvalid once the input word that completes it has passed
// the input register, sum stage and reciprocal multiply stage and entered the result
// queue. Throughput is one word per cycle in both directions while s_tready and m_tready
// stay high; a word with s_tlast adds up to two extra output words, which drain from the
// queue one per cycle. s_tready is driven only from a credit counter: it stays high as long
// as the queue plus the words still in the pipeline leave room for three more results, so
// a stalled receiver backs the stream up before the queue overflows, and nothing is dropped.
// Reset clears the history, the sample count, the queue and the pipeline valid bits, and
// returns the jump threshold to half a turn.
module wrap_guarded_azimuth_smoother
	import wgas_pkg::*;
#(
	parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	// Input stream.
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [AZ_W-1:0]    s_tdata,   // [15:0] azimuth_in
	input  logic               s_tlast,   // last_sample
	// Result stream.
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [AZ_W-1:0]    m_tdata,   // [15:0] azimuth_out
	output logic               m_tuser,   // [0] was_averaged
	output logic               m_tlast,   // run_end
	// Configuration port.
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int AW   = ANGLE_BITS;
	localparam int SW   = AW + 3;               // five-sample sum width
	localparam int PW   = 2 * SW;               // reciprocal product width
	localparam int QIW  = $clog2(QUEUE_DEPTH);
	localparam int CW   = $clog2(QUEUE_DEPTH + 1);
	// floor(2**SW / 5); the estimate it gives is at most one below the true quotient.
	localparam logic [SW-1:0] RECIP = SW'((64'd1 << SW) / 64'd5);

	function automatic logic [AZ_W-1:0] to_out(input logic [AW-1:0] v);
		logic [AW+AZ_W-1:0] e;
		e = {{AZ_W{1'b0}}, v};
		return e[AZ_W-1:0];
	endfunction

	// ------------------------------------------------------------------
	// Configuration register.
	// ------------------------------------------------------------------
	logic [15:0] thr_q;
	logic        reg_hit;

	assign pready  = 1'b1;
	assign reg_hit = (paddr[PADDR_W-1:2] == REG_IDX_JUMP_THR);
	assign prdata  = reg_hit ? {16'd0, thr_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= JUMP_THR_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			thr_q <= pwdata[15:0];
		end
	end

	// ------------------------------------------------------------------
	// Input side: history, sample count and result credits.
	// ------------------------------------------------------------------
	logic [AW-1:0]      hist_q [4];
	logic [2:0]         seen_q;
	logic [CW-1:0]      committed_q;
	logic [AW+AZ_W-1:0] in_ext;
	logic [AW-1:0]      x_in;
	logic               acc;
	logic [1:0]         n_acc;

	assign in_ext   = {{AW{1'b0}}, s_tdata};
	assign x_in     = in_ext[AW-1:0];
	// Room for the worst case of three results keeps the check off the data path.
	assign s_tready = (committed_q <= CW'(QUEUE_DEPTH - MAX_RESULTS));
	assign acc      = s_tvalid && s_tready;

	// Results this word will cause, reserved in the queue at acceptance.
	always_comb begin
		n_acc = (seen_q >= 3'd2) ? 2'd1 : 2'd0;
		if (s_tlast) begin
			n_acc = n_acc + ((seen_q >= 3'd1) ? 2'd2 : 2'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				hist_q[i] <= '0;
			end
			seen_q <= '0;
		end else if (acc) begin
			if (s_tlast) begin
				for (int i = 0; i < 4; i++) begin
					hist_q[i] <= '0;
				end
				seen_q <= '0;
			end else begin
				hist_q[0] <= hist_q[1];
				hist_q[1] <= hist_q[2];
				hist_q[2] <= hist_q[3];
				hist_q[3] <= x_in;
				if (seen_q < 3'd4) begin
					seen_q <= seen_q + 3'd1;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: the window as it stood when the word was accepted.
	// ------------------------------------------------------------------
	logic          v_s1;
	logic [AW-1:0] w_s1 [5];
	logic [2:0]    seen_s1;
	logic          last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			for (int i = 0; i < 4; i++) begin
				w_s1[i] <= hist_q[i];
			end
			w_s1[4] <= x_in;
			seen_s1 <= seen_q;
			last_s1 <= s_tlast;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: window sum and wrap check.
	// ------------------------------------------------------------------
	logic          v_s2;
	logic [SW-1:0] sum_s2;
	logic          jump_s2;
	logic [AW-1:0] h2_s2, h3_s2, x_s2;
	logic [2:0]    seen_s2;
	logic          last_s2;
	logic [SW-1:0] sum_c;
	logic          jump_c;
	logic [AW-1:0] diff_c;

	always_comb begin
		sum_c  = '0;
		jump_c = 1'b0;
		diff_c = '0;
		for (int i = 0; i < 5; i++) begin
			sum_c = sum_c + SW'(w_s1[i]);
		end
		for (int i = 0; i < 4; i++) begin
			diff_c = (w_s1[i] > w_s1[i+1]) ? (w_s1[i] - w_s1[i+1]) : (w_s1[i+1] - w_s1[i]);
			if ({{16{1'b0}}, diff_c} > {{AW{1'b0}}, thr_q}) begin
				jump_c = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			sum_s2  <= sum_c;
			jump_s2 <= jump_c;
			h2_s2   <= w_s1[2];
			h3_s2   <= w_s1[3];
			x_s2    <= w_s1[4];
			seen_s2 <= seen_s1;
			last_s2 <= last_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: reciprocal product for the divide by five.
	// ------------------------------------------------------------------
	logic          v_s3;
	logic [PW-1:0] prod_s3;
	logic [SW-1:0] sum_s3;
	logic          jump_s3;
	logic [AW-1:0] h2_s3, h3_s3, x_s3;
	logic [2:0]    seen_s3;
	logic          last_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			prod_s3 <= PW'(sum_s2) * PW'(RECIP);
			sum_s3  <= sum_s2;
			jump_s3 <= jump_s2;
			h2_s3   <= h2_s2;
			h3_s3   <= h3_s2;
			x_s3    <= x_s2;
			seen_s3 <= seen_s2;
			last_s3 <= last_s2;
		end
	end

	// ------------------------------------------------------------------
	// Quotient correction and result assembly.
	// ------------------------------------------------------------------
	logic [SW-1:0] q0, rem, mean;
	logic          win_avg;
	res_t          e0, e1, e2;
	logic          ev0, ev1, ev2;
	logic [1:0]    pos1, pos2, npush;

	always_comb begin
		q0      = prod_s3[PW-1:SW];
		// True remainder is below ten, so a single compare fixes the estimate.
		rem     = sum_s3 - (q0 << 2) - q0;
		mean    = (rem >= SW'(5)) ? (q0 + SW'(1)) : q0;
		win_avg = (seen_s3 >= 3'd4) && !jump_s3;

		e0.az      = win_avg ? to_out(mean[AW-1:0]) : to_out(h2_s3);
		e0.avg     = win_avg;
		e0.run_end = !last_s3;
		e1.az      = to_out(h3_s3);
		e1.avg     = 1'b0;
		e1.run_end = 1'b0;
		e2.az      = to_out(x_s3);
		e2.avg     = 1'b0;
		e2.run_end = 1'b1;

		ev0   = v_s3 && (seen_s3 >= 3'd2);
		ev1   = v_s3 && last_s3 && (seen_s3 >= 3'd1);
		ev2   = v_s3 && last_s3;
		pos1  = {1'b0, ev0};
		pos2  = {1'b0, ev0} + {1'b0, ev1};
		npush = pos2 + {1'b0, ev2};
	end

	// ------------------------------------------------------------------
	// Result queue.
	// ------------------------------------------------------------------
	res_t           q_mem [QUEUE_DEPTH];
	logic [QIW-1:0] wr_q, rd_q;
	logic [CW-1:0]  qcnt_q;
	logic           pop;
	res_t           head;

	assign head     = q_mem[rd_q];
	assign m_tvalid = (qcnt_q != '0);
	assign m_tdata  = head.az;
	assign m_tuser  = head.avg;
	assign m_tlast  = head.run_end;
	assign pop      = m_tvalid && m_tready;

	always_ff @(posedge clk) begin
		if (ev0) begin
			q_mem[wr_q] <= e0;
		end
		if (ev1) begin
			q_mem[wr_q + QIW'(pos1)] <= e1;
		end
		if (ev2) begin
			q_mem[wr_q + QIW'(pos2)] <= e2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q        <= '0;
			rd_q        <= '0;
			qcnt_q      <= '0;
			committed_q <= '0;
		end else begin
			wr_q        <= wr_q + QIW'(npush);
			rd_q        <= rd_q + QIW'(pop);
			qcnt_q      <= qcnt_q + CW'(npush) - CW'(pop);
			committed_q <= committed_q + (acc ? CW'(n_acc) : CW'(0)) - CW'(pop);
		end
	end

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	// Reserved results never exceed the queue, so pushes cannot overwrite.
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		committed_q <= CW'(QUEUE_DEPTH))
		else $error("result credits exceed queue depth");

	// Queued results are always covered by reserved credits.
	a_queue_covered: assert property (@(posedge clk) disable iff (!arst_n)
		qcnt_q <= committed_q)
		else $error("queue holds more words than were reserved");

	// With nothing in flight and the queue empty, no credits may remain.
	a_credit_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(!v_s1 && !v_s2 && !v_s3 && qcnt_q == '0) |-> committed_q == '0)
		else $error("credits leaked with the block idle");

	// The end of a run returns the sample count to zero.
	a_run_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && s_tlast) |=> seen_q == 3'd0)
		else $error("sample count not cleared at end of run");

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the wrap-guarded five-point azimuth smoother.
`timescale 1ns / 100ps

module testbench;
	import wgas_pkg::*;

	// Clock period is 12 ns; the clock flips every half period.
	localparam int HALF_PERIOD = 6;

	// A phase ends by waiting this many cycles after the last expected word,
	// which covers its three-stage latency with margin.
	localparam int DRAIN_CYCLES = 10;

	// Cycles without any handshake before the run is declared hung.
	localparam int WATCHDOG_LIMIT = 1000;

	// Length of the deliberate receiver hold-off that backs up the block.
	localparam int LONG_HOLD_CYCLES = 60;

	// Minimum random words per randomized phase; the last run may go past it.
	localparam int PHASE_WORDS = 58;

	// Register byte addresses: the jump threshold, and an address that decodes
	// to no register and must leave the threshold alone.
	localparam logic [PADDR_W-1:0] ADDR_JUMP_THR = PADDR_W'(REG_IDX_JUMP_THR) << 2;
	localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = PADDR_W'(4);

	// Shapes of random heading runs.
	typedef enum int {
		TRACK_SMOOTH,
		TRACK_NOISY,
		TRACK_NEAR_THR
	} track_kind_e;

	// One heading word waiting to be offered on the input stream.
	typedef struct {
		logic [AZ_W-1:0] az;
		logic            last;
	} heading_word_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [AZ_W-1:0]    s_tdata = '0;   // [15:0] azimuth_in
	logic               s_tlast = 1'b0; // last_sample
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [AZ_W-1:0]    m_tdata;        // [15:0] azimuth_out
	logic               m_tuser;        // [0] was_averaged
	logic               m_tlast;        // run_end
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	wrap_guarded_azimuth_smoother u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #HALF_PERIOD clk = ~clk;

	// Words still to be offered, and the smoothed words the block owes us.
	heading_word_t heading_q[$];
	res_t          smoothed_q[$];

	// Shadow copy of the block's state and its one register.
	logic [AZ_W-1:0] hist [4];
	int unsigned     seen;
	logic [15:0]     jump_thr_model = JUMP_THR_RESET;

	// Handshake bookkeeping shared between the driver and the monitor.
	bit          in_taken = 1'b0;
	int unsigned in_gap = 0;
	int unsigned out_gap = 0;
	int unsigned hold_left = 0;
	bit          long_hold_req = 1'b0;
	bit          quiet = 1'b0;

	int unsigned errors = 0;
	int unsigned words_in = 0;
	int unsigned words_out = 0;
	int unsigned words_averaged = 0;
	int unsigned runs_sent = 0;
	int unsigned thr_settings = 0;
	int unsigned idle_cycles = 0;

	heading_word_t next_word;
	res_t          want;

	// Works out every result word that one accepted heading word causes and
	// appends them to smoothed_q. A sample is released two words after it
	// arrives; it is averaged only once a full five-sample window exists and
	// no neighbor difference in that window is above the threshold.
	task automatic predict_smoothed(input logic [AZ_W-1:0] az_in, input logic last);
		res_t            outs [3];
		int              k;
		logic [AZ_W-1:0] win [5];
		bit              blocked;
		int              diff;
		int unsigned     sum;
		k = 0;
		if (seen >= 2) begin
			outs[k] = '{az: hist[2], avg: 1'b0, run_end: 1'b0};
			if (seen >= 4) begin
				win[0] = hist[0];
				win[1] = hist[1];
				win[2] = hist[2];
				win[3] = hist[3];
				win[4] = az_in;
				blocked = 1'b0;
				sum = 0;
				for (int i = 0; i < 5; i++) begin
					sum += win[i];
				end
				for (int i = 0; i < 4; i++) begin
					diff = int'(win[i]) - int'(win[i+1]);
					if (diff < 0) begin
						diff = -diff;
					end
					if (diff > int'(jump_thr_model)) begin
						blocked = 1'b1;
					end
				end
				if (!blocked) begin
					outs[k].az = AZ_W'(sum / 5);
					outs[k].avg = 1'b1;
				end
			end
			k++;
		end
		if (last) begin
			// End of run: flush what is still held, then start over from scratch.
			if (seen >= 1) begin
				outs[k] = '{az: hist[3], avg: 1'b0, run_end: 1'b0};
				k++;
			end
			outs[k] = '{az: az_in, avg: 1'b0, run_end: 1'b0};
			k++;
			for (int i = 0; i < 4; i++) begin
				hist[i] = '0;
			end
			seen = 0;
		end else begin
			hist[0] = hist[1];
			hist[1] = hist[2];
			hist[2] = hist[3];
			hist[3] = az_in;
			if (seen < 4) begin
				seen++;
			end
		end
		if (k > 0) begin
			outs[k-1].run_end = 1'b1;
		end
		for (int i = 0; i < k; i++) begin
			smoothed_q.push_back(outs[i]);
		end
	endtask

	// Input driver. A word stays on the bus until the monitor has seen it
	// taken; only then does the driver pick an idle burst or the next word.
	always @(negedge clk) begin
		if (arst_n && (!s_tvalid || in_taken)) begin
			in_taken = 1'b0;
			if (in_gap != 0) begin
				in_gap--;
				s_tvalid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				in_gap = $urandom_range(0, 3);
				s_tvalid <= 1'b0;
			end else if (heading_q.size() != 0) begin
				next_word = heading_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= next_word.az;
				s_tlast <= next_word.last;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Result receiver. A requested long hold-off takes priority and is
	// counted down here; otherwise ready drops in short random bursts.
	always @(negedge clk) begin
		if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_left = LONG_HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (out_gap != 0) begin
			out_gap--;
			m_tready <= 1'b0;
		end else if (!quiet && arst_n && $urandom_range(0, 5) == 0) begin
			out_gap = $urandom_range(0, 3);
			m_tready <= 1'b0;
		end else begin
			m_tready <= arst_n;
		end
	end

	// Monitor: checks each result word against the oldest expectation and
	// feeds each accepted input word to the predictor. Results trail inputs
	// through the pipeline registers, so the order of the two within one edge is free.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				words_out++;
				if (smoothed_q.size() == 0) begin
					$error("result word with nothing expected: azimuth_out %h", m_tdata);
					errors++;
				end else begin
					want = smoothed_q.pop_front();
					if (m_tdata !== want.az) begin
						$error("azimuth_out: expected %h, actual %h", want.az, m_tdata);
						errors++;
					end
					if (m_tuser !== want.avg) begin
						$error("was_averaged: expected %b, actual %b", want.avg, m_tuser);
						errors++;
					end
					if (m_tlast !== want.run_end) begin
						$error("run_end: expected %b, actual %b", want.run_end, m_tlast);
						errors++;
					end
					if (want.avg) begin
						words_averaged++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				in_taken = 1'b1;
				words_in++;
				predict_smoothed(s_tdata, s_tlast);
			end
		end
	end

	// Watchdog: any handshake on either stream or the register port counts as
	// progress; a long stretch without one means the block has hung.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Register write: setup cycle, then access cycle. The shadow threshold
	// follows only writes to the threshold register's byte address.
	task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [15:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= {16'h0000, value};
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_JUMP_THR) begin
			jump_thr_model = value;
			thr_settings++;
		end
	endtask

	// Reads the threshold back and compares it with the shadow copy.
	task automatic check_thr_readback();
		logic [31:0] got;
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		paddr <= ADDR_JUMP_THR;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		got = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (got !== {16'h0000, jump_thr_model}) begin
			$error("jump_threshold: expected %h, actual %h", {16'h0000, jump_thr_model}, got);
			errors++;
		end
	endtask

	task automatic queue_heading(input logic [AZ_W-1:0] az, input logic last);
		heading_word_t w;
		w.az = az;
		w.last = last;
		heading_q.push_back(w);
		if (last) begin
			runs_sent++;
		end
	endtask

	// One run of random content closed by last_sample. Smooth tracks let the
	// averaging path work and still wander across north; noisy ones hit the
	// wrap guard; the near-threshold ones step by about the threshold itself.
	task automatic queue_random_run(input int len, output int queued);
		track_kind_e     kind;
		logic [AZ_W-1:0] az;
		int              step;
		int              pick;
		pick = $urandom_range(0, 9);
		kind = (pick < 6) ? TRACK_SMOOTH : (pick < 8) ? TRACK_NOISY : TRACK_NEAR_THR;
		az = AZ_W'($urandom());
		for (int i = 0; i < len; i++) begin
			queue_heading(az, i == len - 1);
			case (kind)
				TRACK_SMOOTH: begin
					step = int'($urandom_range(0, 1023)) - 512;
				end
				TRACK_NOISY: begin
					step = int'($urandom_range(0, 65535));
				end
				default: begin
					step = int'(jump_thr_model) + int'($urandom_range(0, 2)) - 1;
					if ($urandom_range(0, 1) == 1) begin
						step = -step;
					end
				end
			endcase
			az = AZ_W'(int'(az) + step);
		end
		queued = len;
	endtask

	// Waits until every word has been offered and taken and every expected
	// result has arrived, then lets the pipeline settle before the next write.
	task automatic wait_idle();
		while (heading_q.size() != 0 || s_tvalid || smoothed_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_phase(input logic [15:0] thr, input bit with_hold);
		int total;
		int got;
		reg_write(ADDR_JUMP_THR, thr);
		check_thr_readback();
		total = 0;
		while (total < PHASE_WORDS) begin
			// Mostly medium runs, now and then a very short one.
			if ($urandom_range(0, 4) == 0) begin
				queue_random_run($urandom_range(1, 3), got);
			end else begin
				queue_random_run($urandom_range(4, 14), got);
			end
			total += got;
		end
		if (with_hold) begin
			long_hold_req = 1'b1;
		end
		wait_idle();
	endtask

	initial begin
		for (int i = 0; i < 4; i++) begin
			hist[i] = '0;
		end
		seen = 0;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Threshold comes out of reset at half a turn.
		check_thr_readback();

		// Directed runs at the reset threshold.
		// A run of one word: it comes straight back, passed through.
		queue_heading(16'hFFFF, 1'b1);
		// A run of two: both words are flushed by the last one.
		queue_heading(16'h1234, 1'b0);
		queue_heading(16'h0000, 1'b1);
		// A run of three: the first is released normally, two are flushed.
		queue_heading(16'h0001, 1'b0);
		queue_heading(16'h0002, 1'b0);
		queue_heading(16'h0003, 1'b1);
		// Full scale everywhere: the window sum is at its largest.
		for (int i = 0; i < 5; i++) begin
			queue_heading(16'hFFFF, i == 4);
		end
		// Heading crossing north: the jump blocks averaging.
		queue_heading(16'hFFF0, 1'b0);
		queue_heading(16'hFFF8, 1'b0);
		queue_heading(16'h0008, 1'b0);
		queue_heading(16'h0010, 1'b0);
		queue_heading(16'h0018, 1'b1);
		// Neighbor differences exactly at the threshold still get averaged.
		queue_heading(16'h0000, 1'b0);
		queue_heading(16'h8000, 1'b0);
		queue_heading(16'h0000, 1'b0);
		queue_heading(16'h8000, 1'b0);
		queue_heading(16'h0000, 1'b1);
		wait_idle();

		// A write to an address with no register must change nothing.
		reg_write(ADDR_UNMAPPED, 16'h1357);
		check_thr_readback();

		// Zero threshold: only a perfectly flat window is averaged.
		reg_write(ADDR_JUMP_THR, 16'h0000);
		check_thr_readback();
		for (int i = 0; i < 5; i++) begin
			queue_heading(16'h0005, 1'b0);
		end
		queue_heading(16'h0006, 1'b1);
		wait_idle();

		// Full-scale threshold: nothing can block averaging.
		reg_write(ADDR_JUMP_THR, 16'hFFFF);
		check_thr_readback();
		queue_heading(16'h0000, 1'b0);
		queue_heading(16'hFFFF, 1'b0);
		queue_heading(16'h0000, 1'b0);
		queue_heading(16'hFFFF, 1'b0);
		queue_heading(16'h0000, 1'b1);
		wait_idle();

		// Randomized phases across a spread of thresholds. The second one holds
		// the receiver off long enough for the block to stop taking input.
		random_phase(16'($urandom()), 1'b0);
		random_phase(16'h0000, 1'b1);
		random_phase(16'hFFFF, 1'b0);
		random_phase(JUMP_THR_RESET, 1'b0);
		random_phase(16'($urandom_range(0, 1024)), 1'b0);
		quiet = 1'b1;
		random_phase(16'($urandom()), 1'b0);

		$display("Covered %0d heading words in %0d runs, %0d result words (%0d averaged),",
			words_in, runs_sent, words_out, words_averaged);
		$display("over %0d threshold settings including both extremes and the reset value.",
			thr_settings);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/wgas_pkg.sv
sv/wrap_guarded_azimuth_smoother.sv
verif/testbench.sv
